>>> hdl/scancode_to_ascii_translator_defines.svh
// ----------------------------------------------------------------------------
// Scan code translator assertion macros
// Shared concurrent assertion forms, clocked on clk_i and reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_TO_ASCII_TRANSLATOR_DEFINES_SVH
`define SCANCODE_TO_ASCII_TRANSLATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define S2A_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define S2A_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/s2a_pkg.sv
// ----------------------------------------------------------------------------
// Scan code translator package
// Scan code constants, the modifier state type and the character tables.
// ----------------------------------------------------------------------------
package s2a_pkg;

  localparam int unsigned KEY_COUNT = 58;
  localparam int unsigned KEY_IDX_W = 6;
  localparam int unsigned CHAR_W    = 7;

  // Scan code set 1 bytes with a special meaning.
  localparam logic [7:0] SC_PREFIX      = 8'hE0;
  localparam logic [7:0] SC_ALT_MAKE    = 8'h38;
  localparam logic [7:0] SC_ALT_BREAK   = 8'hB8;
  localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
  localparam logic [7:0] SC_CTRL_MAKE   = 8'h1D;
  localparam logic [7:0] SC_CTRL_BREAK  = 8'h9D;
  localparam logic [7:0] SC_CAPS_MAKE   = 8'h3A;

  // Case flip between lower and upper case letters.
  localparam logic [CHAR_W-1:0] CASE_BIT = 7'h20;

  // Modifier state that selects the character table.
  typedef struct packed {
    logic shift;
    logic caps;
  } mod_state_t;

  localparam logic [CHAR_W-1:0] PLAIN_TAB [KEY_COUNT] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00, 7'h00, 7'h20
  };

  localparam logic [CHAR_W-1:0] SHIFT_TAB [KEY_COUNT] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00, 7'h00, 7'h20
  };

endpackage

>>> hdl/s2a_keymap.sv
// ----------------------------------------------------------------------------
// Scan code translator key map
// Looks up the character of a make code and applies caps lock to letters.
// ----------------------------------------------------------------------------
module s2a_keymap (
  input  logic [s2a_pkg::KEY_IDX_W-1:0] key_idx_i,
  input  s2a_pkg::mod_state_t           mods_i,
  output logic [s2a_pkg::CHAR_W-1:0]    char_code_o
);

  logic [s2a_pkg::CHAR_W-1:0] base_char;
  logic                       is_letter;

  // Table lookup; indexes past the last key read as an unmapped key.
  always_comb begin
    base_char = '0;
    if (32'(key_idx_i) < s2a_pkg::KEY_COUNT) begin
      base_char = mods_i.shift ? s2a_pkg::SHIFT_TAB[key_idx_i]
                               : s2a_pkg::PLAIN_TAB[key_idx_i];
    end
  end

  // Caps lock flips the case of letters only.
  assign is_letter = ((base_char >= 7'h61) && (base_char <= 7'h7A)) ||
                     ((base_char >= 7'h41) && (base_char <= 7'h5A));

  assign char_code_o = (mods_i.caps && is_letter) ? (base_char ^ s2a_pkg::CASE_BIT)
                                                  : base_char;

endmodule

>>> hdl/scancode_to_ascii_translator.sv
// ----------------------------------------------------------------------------
// Scan code set 1 to ASCII translator with a single registered lookup stage.
// Throughput 1 byte per cycle while no finished result is stalled.
// Reset clears all modifiers, the prefix flag and the output valid flag.
// ----------------------------------------------------------------------------
`include "scancode_to_ascii_translator_defines.svh"

module scancode_to_ascii_translator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 scan_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [s2a_pkg::CHAR_W-1:0] char_code_o
);

  logic shift_q, shift_d;
  logic caps_q, caps_d;
  logic ctrl_q, ctrl_d;
  logic alt_q, alt_d;
  logic prefix_q, prefix_d;
  logic out_valid_q, out_valid_d;
  logic [s2a_pkg::CHAR_W-1:0] char_q;

  logic                       in_acc;
  logic                       emit;
  s2a_pkg::mod_state_t        mods;
  logic [s2a_pkg::CHAR_W-1:0] lookup_char;
  logic                       prefix_acc;
  logic                       caps_acc;
  logic                       alt_acc;

  // A new transaction is taken unless a finished result is stalled.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign mods = s2a_pkg::mod_state_t'{shift: shift_q, caps: caps_q};

  s2a_keymap u_keymap (
    .key_idx_i   (scan_byte_i[s2a_pkg::KEY_IDX_W-1:0]),
    .mods_i      (mods),
    .char_code_o (lookup_char)
  );

  // Modifier decode; the prefix only changes its own flag.
  always_comb begin
    shift_d  = shift_q;
    caps_d   = caps_q;
    ctrl_d   = ctrl_q;
    alt_d    = alt_q;
    prefix_d = prefix_q;
    emit     = 1'b0;
    if (in_acc) begin
      if (scan_byte_i == s2a_pkg::SC_PREFIX) begin
        prefix_d = 1'b1;
      end else begin
        prefix_d = 1'b0;
        unique case (scan_byte_i) inside
          s2a_pkg::SC_ALT_MAKE:  alt_d = 1'b1;
          s2a_pkg::SC_ALT_BREAK: alt_d = 1'b0;
          s2a_pkg::SC_LSHIFT_MAKE, s2a_pkg::SC_RSHIFT_MAKE: shift_d = 1'b1;
          s2a_pkg::SC_LSHIFT_BRK, s2a_pkg::SC_RSHIFT_BRK:   shift_d = 1'b0;
          s2a_pkg::SC_CTRL_MAKE:  ctrl_d = 1'b1;
          s2a_pkg::SC_CTRL_BREAK: ctrl_d = 1'b0;
          s2a_pkg::SC_CAPS_MAKE:  caps_d = !caps_q;
          default: emit = !ctrl_q && (32'(scan_byte_i) < s2a_pkg::KEY_COUNT);
        endcase
      end
    end
  end

  // Output valid: loaded on a transaction, cleared once the result is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = emit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Modifier state and result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= 1'b0;
      caps_q      <= 1'b0;
      ctrl_q      <= 1'b0;
      alt_q       <= 1'b0;
      prefix_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      shift_q     <= shift_d;
      caps_q      <= caps_d;
      ctrl_q      <= ctrl_d;
      alt_q       <= alt_d;
      prefix_q    <= prefix_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result character register.
  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      char_q <= lookup_char;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;

  // Accepted transactions of the codes that the checks below look at.
  assign prefix_acc = in_acc && (scan_byte_i == s2a_pkg::SC_PREFIX);
  assign caps_acc   = in_acc && (scan_byte_i == s2a_pkg::SC_CAPS_MAKE);
  assign alt_acc    = in_acc && (scan_byte_i == s2a_pkg::SC_ALT_MAKE);

  // Checks on the modifier tracking and the result register.
  `S2A_ASSERT_NEXT(a_prefix_set, prefix_acc, prefix_q, "prefix flag not set")
  `S2A_ASSERT_NEXT(a_caps_toggle, caps_acc, caps_q != $past(caps_q), "caps lock did not toggle")
  `S2A_ASSERT_NEXT(a_alt_quiet, alt_acc, alt_q && !out_valid_q, "alt make mishandled")
  `S2A_ASSERT_NOW(a_result_source, $rose(out_valid_q), $past(in_acc && !ctrl_q), "stray result")

endmodule

>>> sim/scancode_to_ascii_translator_tb.sv
// ----------------------------------------------------------------------------
// Scan code set 1 to ASCII translator testbench
// Sends scan code bytes through the valid/stall input channel. A shadow
// translator keeps its own modifier and prefix state and queues each expected
// character. The monitor checks every character that arrives against that
// queue. A short directed sequence runs first, then random typing sequences
// with noise. The sender and the receiver idle in several patterns.
// ----------------------------------------------------------------------------
module scancode_to_ascii_translator_tb;

  // Idle pattern applied to one stretch of the traffic.
  typedef enum logic [1:0] {
    IDLE_OFF,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // One keyboard byte waiting to be sent, with the idle pattern of its stretch.
  typedef struct packed {
    logic [7:0] code;
    idle_mode_e mode;
  } key_event_t;

  localparam int unsigned RANDOM_BYTES = 1850;
  localparam int unsigned STRETCH_LEN  = 160;
  localparam int unsigned TAIL_CYCLES  = 16;
  localparam logic [7:0]  BREAK_BIT    = 8'h80;

  // Opening sequence: table extremes, every modifier, prefixed forms, and
  // codes that give no character.
  localparam int unsigned DIRECTED_LEN = 30;
  localparam logic [7:0] DIRECTED_BYTES [DIRECTED_LEN] = '{
    8'h00, 8'h01, 8'h39, 8'h2A, 8'h10, 8'h02, 8'hAA, 8'h36, 8'h3A, 8'h1E,
    8'hB6, 8'h1E, 8'h3A, 8'h1D, 8'h1E, 8'h9D, 8'hE0, 8'h1D, 8'hE0, 8'h9D,
    8'h38, 8'hB8, 8'hE0, 8'h2A, 8'hE0, 8'hAA, 8'hFF, 8'h3A, 8'hE0, 8'hE0
  };

  // Characters of keys 0 to 57 without shift.
  localparam logic [s2a_pkg::CHAR_W-1:0] UNSHIFTED_CHARS [s2a_pkg::KEY_COUNT] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00, 7'h00, 7'h20
  };

  // Characters of keys 0 to 57 with shift held.
  localparam logic [s2a_pkg::CHAR_W-1:0] SHIFTED_CHARS [s2a_pkg::KEY_COUNT] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00, 7'h00, 7'h20
  };

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic [7:0]                 scan_byte_i = 8'h00;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [s2a_pkg::CHAR_W-1:0] char_code_o;

  key_event_t                 pending_events [$];
  logic [s2a_pkg::CHAR_W-1:0] expected_chars [$];
  idle_mode_e                 receiver_mode = IDLE_OFF;
  int unsigned                queued_count   = 0;
  int unsigned                bytes_accepted = 0;
  int unsigned                chars_checked  = 0;
  int unsigned                error_count    = 0;

  // Shadow state of the translator.
  logic shift_held  = 1'b0;
  logic caps_on     = 1'b0;
  logic ctrl_held   = 1'b0;
  logic alt_held    = 1'b0;
  logic prefix_seen = 1'b0;

  scancode_to_ascii_translator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .scan_byte_i (scan_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Queues one byte; the stretch it falls in sets its idle pattern.
  task automatic queue_byte(input logic [7:0] code);
    key_event_t ev;
    ev.code = code;
    if (queued_count < DIRECTED_LEN) begin
      ev.mode = IDLE_OFF;
    end else begin
      ev.mode = idle_mode_e'(((queued_count - DIRECTED_LEN) / STRETCH_LEN) % 4);
    end
    pending_events.push_back(ev);
    queued_count++;
  endtask

  // Decides whether one side pauses in this cycle under the given pattern.
  function automatic bit idle_roll(input idle_mode_e mode, input bit is_sender);
    bit own_side;
    own_side = is_sender ? (mode == IDLE_SENDER) : (mode == IDLE_RECEIVER);
    if (own_side) begin
      return $urandom_range(99) < 77;
    end
    if (mode == IDLE_BOTH) begin
      return $urandom_range(99) < 38;
    end
    return 1'b0;
  endfunction

  // Updates the shadow state for one accepted byte and queues the character
  // that it produces, if any.
  task automatic translate_byte(input logic [7:0] code);
    logic [s2a_pkg::CHAR_W-1:0] ch;
    if (code == s2a_pkg::SC_PREFIX) begin
      prefix_seen = 1'b1;
      return;
    end
    // Only the ctrl codes treat the prefix specially; other bytes fall through.
    if (prefix_seen) begin
      prefix_seen = 1'b0;
      if (code == s2a_pkg::SC_CTRL_MAKE) begin
        ctrl_held = 1'b1;
        return;
      end
      if (code == s2a_pkg::SC_CTRL_BREAK) begin
        ctrl_held = 1'b0;
        return;
      end
    end
    case (code)
      s2a_pkg::SC_ALT_MAKE: begin
        alt_held = 1'b1;
        return;
      end
      s2a_pkg::SC_ALT_BREAK: begin
        alt_held = 1'b0;
        return;
      end
      s2a_pkg::SC_LSHIFT_MAKE, s2a_pkg::SC_RSHIFT_MAKE: begin
        shift_held = 1'b1;
        return;
      end
      s2a_pkg::SC_LSHIFT_BRK, s2a_pkg::SC_RSHIFT_BRK: begin
        shift_held = 1'b0;
        return;
      end
      s2a_pkg::SC_CTRL_MAKE: begin
        ctrl_held = 1'b1;
        return;
      end
      s2a_pkg::SC_CTRL_BREAK: begin
        ctrl_held = 1'b0;
        return;
      end
      s2a_pkg::SC_CAPS_MAKE: begin
        caps_on = !caps_on;
        return;
      end
      default: ;
    endcase
    // Ctrl swallows everything else, and codes past the tables give nothing.
    if (ctrl_held || code >= s2a_pkg::KEY_COUNT) begin
      return;
    end
    ch = shift_held ? SHIFTED_CHARS[code] : UNSHIFTED_CHARS[code];
    // Caps lock flips the case of letters only.
    if (caps_on && ((ch >= 7'h61 && ch <= 7'h7A) || (ch >= 7'h41 && ch <= 7'h5A))) begin
      ch = ch ^ s2a_pkg::CASE_BIT;
    end
    expected_chars.push_back(ch);
  endtask

  // Driver: presents the head of the pending queue and predicts on acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        translate_byte(scan_byte_i);
        pending_events.delete(0);
        bytes_accepted++;
      end
      // A stalled transaction keeps its byte until it is taken.
      if (!in_valid_i || !in_stall_o) begin
        if (pending_events.size() != 0 && !idle_roll(pending_events[0].mode, 1'b1)) begin
          in_valid_i    <= 1'b1;
          scan_byte_i   <= pending_events[0].code;
          receiver_mode <= pending_events[0].mode;
        end else begin
          in_valid_i  <= 1'b0;
          scan_byte_i <= 8'($urandom_range(255));
        end
      end
    end
  end

  // Monitor: checks each character transaction against the oldest expectation.
  always @(posedge clk_i) begin
    logic [s2a_pkg::CHAR_W-1:0] want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected character: expected none, got 0x%02h",
                   $time, char_code_o);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          chars_checked++;
          if (char_code_o !== want) begin
            $display("%0t: char_code mismatch: expected 0x%02h, got 0x%02h",
                     $time, want, char_code_o);
            error_count++;
          end
        end
      end
      out_stall_i <= idle_roll(receiver_mode, 1'b0);
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned pick;
    int unsigned burst;
    logic [7:0]  key;

    foreach (DIRECTED_BYTES[i]) begin
      queue_byte(DIRECTED_BYTES[i]);
    end

    // Random typing: mostly key presses with releases, modifier traffic,
    // prefixed bytes and raw noise.
    while (queued_count < DIRECTED_LEN + RANDOM_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        key = 8'($urandom_range(s2a_pkg::KEY_COUNT - 1));
        queue_byte(key);
        if ($urandom_range(9) < 7) begin
          queue_byte(key | BREAK_BIT);
        end
      end else if (pick < 65) begin
        if ($urandom_range(3) == 0) begin
          queue_byte(s2a_pkg::SC_PREFIX);
        end
        key = $urandom_range(1) ? s2a_pkg::SC_LSHIFT_MAKE : s2a_pkg::SC_RSHIFT_MAKE;
        if ($urandom_range(1)) begin
          key = key | BREAK_BIT;
        end
        queue_byte(key);
      end else if (pick < 70) begin
        queue_byte(s2a_pkg::SC_CAPS_MAKE);
        if ($urandom_range(1)) begin
          queue_byte(s2a_pkg::SC_CAPS_MAKE | BREAK_BIT);
        end
      end else if (pick < 75) begin
        // Ctrl chord, plain or extended, around a few keys that get dropped.
        if ($urandom_range(1)) begin
          queue_byte(s2a_pkg::SC_PREFIX);
        end
        queue_byte(s2a_pkg::SC_CTRL_MAKE);
        burst = $urandom_range(1, 3);
        repeat (burst) queue_byte(8'($urandom_range(s2a_pkg::KEY_COUNT - 1)));
        if ($urandom_range(1)) begin
          queue_byte(s2a_pkg::SC_PREFIX);
        end
        queue_byte(s2a_pkg::SC_CTRL_BREAK);
      end else if (pick < 80) begin
        if ($urandom_range(1)) begin
          queue_byte(s2a_pkg::SC_PREFIX);
        end
        queue_byte(s2a_pkg::SC_ALT_MAKE);
        queue_byte(8'($urandom_range(s2a_pkg::KEY_COUNT - 1)));
        if ($urandom_range(1)) begin
          queue_byte(s2a_pkg::SC_PREFIX);
        end
        queue_byte(s2a_pkg::SC_ALT_BREAK);
      end else if (pick < 85) begin
        queue_byte(s2a_pkg::SC_PREFIX);
        queue_byte(8'($urandom_range(255)));
      end else begin
        queue_byte(8'($urandom_range(255)));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_events.size() != 0 || expected_chars.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d scan code bytes (typing, modifiers, prefixes, noise) under",
             bytes_accepted);
    $display("four idle patterns; %0d characters checked.", chars_checked);
    if (error_count == 0) begin
      $display("** scancode_to_ascii_translator: PASSED **");
    end else begin
      $display("** scancode_to_ascii_translator: FAILED **");
    end
    $finish;
  end

  // Watchdog on a hung handshake.
  initial begin
    #(12 * 500000);
    $display("Timeout with %0d bytes pending and %0d characters outstanding.",
             pending_events.size(), expected_chars.size());
    $display("** scancode_to_ascii_translator: FAILED **");
    $finish;
  end

endmodule
